// ----- sv/plob_pkg.sv -----
// shared types and constants for the price level order book
package plob_pkg;
    localparam int PRICE_W = 36;
    localparam int QTY_W   = 24;
    localparam int SIZE_W  = 32;
    localparam int CNT_W   = 16;
    localparam int IDX_W   = 4;
    localparam int DEPTH_CAP = 11;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TRADE  = 2'd2,
        CMD_FILL   = 2'd3
    } cmd_t;

    localparam logic [1:0] SIDE_BID  = 2'd0;
    localparam logic [1:0] SIDE_ASK  = 2'd1;
    localparam logic [1:0] PEND_TRADE = 2'd2;
    localparam logic [1:0] PEND_MAX   = 2'd3;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [SIZE_W-1:0]  size;
        logic [CNT_W-1:0]   count;
    } level_t;
endpackage

// ----- sv/price_level_order_book_unit.sv -----
// top level of the price level order book with top of book snapshot
//
// channel | direction | handshake           | payload
// in      | into      | in_valid/in_stall   | command side price quantity
// out     | out of    | out_valid/out_stall | level_index, bid_*, ask_*, event_depth,
//         |           |                     | as_trade, last
//
// an add or cancel is accepted, searches its side level by level (ST_SRCH_RD, ST_SRCH),
// updates the level found (ST_UPD), moves entries to insert or remove one (ST_MOVE_RD,
// ST_MOVE_WR), scans the depth (at most DEPTH_CAP + 1 levels) and reads out the snapshot
// transfers (ST_OUT_RD, ST_OUT); trade and fill events give no transfer
// reset clears the level counts and the pending count; table contents need no clear
// out_stall holds the current snapshot transfer; in_stall is high while busy
module price_level_order_book_unit #(
    parameter int MAX_LEVELS = 256,
    parameter int TOP_LEVELS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     command,
    input  logic [1:0]                     side,
    input  logic [plob_pkg::PRICE_W-1:0]   price,
    input  logic [plob_pkg::QTY_W-1:0]     quantity,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [plob_pkg::IDX_W-1:0]     level_index,
    output logic [plob_pkg::PRICE_W-1:0]   bid_price,
    output logic [plob_pkg::SIZE_W-1:0]    bid_total,
    output logic [plob_pkg::CNT_W-1:0]     bid_orders,
    output logic                           bid_present,
    output logic [plob_pkg::PRICE_W-1:0]   ask_price,
    output logic [plob_pkg::SIZE_W-1:0]    ask_total,
    output logic [plob_pkg::CNT_W-1:0]     ask_orders,
    output logic                           ask_present,
    output logic [plob_pkg::IDX_W-1:0]     event_depth,
    output logic                           as_trade,
    output logic                           last
);
    import plob_pkg::*;

    localparam int AW = $clog2(MAX_LEVELS);
    localparam int NW = $clog2(MAX_LEVELS + 1);
    localparam int KW = $clog2(TOP_LEVELS + 1);
    localparam logic [NW-1:0] N_MAX = NW'(MAX_LEVELS);
    localparam logic [KW-1:0] K_TOP = KW'(TOP_LEVELS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SRCH_RD, ST_SRCH, ST_UPD, ST_MOVE_RD, ST_MOVE_WR,
        ST_DEP_RD, ST_DEP, ST_OUT_RD, ST_OUT
    } state_t;

    level_t bid_mem [MAX_LEVELS];
    level_t ask_mem [MAX_LEVELS];

    state_t             state_reg;
    logic [NW-1:0]      bid_used_reg, ask_used_reg;
    logic [1:0]         pend_reg;
    logic               is_bid_reg, is_add_reg, trade_reg;
    logic [PRICE_W-1:0] px_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic [NW-1:0]      idx_reg;
    logic [NW-1:0]      pos_reg;
    logic               insert_reg;
    logic [KW-1:0]      k_reg;
    level_t             bid_rd_reg, ask_rd_reg;
    logic [IDX_W-1:0]   depth_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   oidx_reg;
    level_t             obid_reg, oask_reg;
    logic               obp_reg, oap_reg, olast_reg;

    logic [NW-1:0] ev_used;
    level_t        ev_rd;
    logic          better, at_end;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    level_t        wr_data;
    logic [SIZE_W:0] sum;

    assign ev_used = is_bid_reg ? bid_used_reg : ask_used_reg;
    assign ev_rd   = is_bid_reg ? bid_rd_reg : ask_rd_reg;
    assign better  = is_bid_reg ? (ev_rd.price > px_reg) : (ev_rd.price < px_reg);
    assign at_end  = idx_reg >= ev_used;
    assign sum     = {1'b0, ev_rd.size} + {{(SIZE_W-QTY_W+1){1'b0}}, qty_reg};

    always_ff @(posedge clk)
    begin
        bid_rd_reg <= bid_mem[rd_addr];
        ask_rd_reg <= ask_mem[rd_addr];
        if (wr_en && is_bid_reg)
            bid_mem[wr_addr] <= wr_data;
        if (wr_en && !is_bid_reg)
            ask_mem[wr_addr] <= wr_data;
    end

    // shared read address, write port and next-state selection
    state_t        state_next;
    logic [NW-1:0] idx_next, pos_next, used_next;
    logic          insert_next, used_we;
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        insert_next = insert_reg;
        used_next   = ev_used;
        used_we     = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = pos_reg[AW-1:0];
        wr_data     = ev_rd;
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = '0;
                if (in_valid && !out_valid_reg &&
                    (command == CMD_ADD || command == CMD_CANCEL))
                begin
                    idx_next   = '0;
                    state_next = (side == SIDE_BID || side == SIDE_ASK)
                                 ? ST_SRCH_RD : ST_DEP_RD;
                end
            end
            ST_SRCH_RD: state_next = ST_SRCH;
            ST_SRCH:
            begin
                if (at_end || !better)
                begin
                    pos_next   = idx_reg;
                    state_next = ST_UPD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    rd_addr    = idx_next[AW-1:0];
                    state_next = ST_SRCH_RD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_DEP_RD;
                idx_next   = '0;
                if (!at_end && ev_rd.price == px_reg)
                begin
                    wr_en = 1'b1;
                    if (is_add_reg)
                    begin
                        wr_data.size  = sum[SIZE_W] ? '1 : sum[SIZE_W-1:0];
                        wr_data.count = (ev_rd.count == '1) ? ev_rd.count
                                                            : ev_rd.count + 1'b1;
                    end
                    else if ({8'd0, qty_reg} >= ev_rd.size)
                    begin
                        wr_en       = 1'b0;
                        insert_next = 1'b0;
                        idx_next    = pos_reg + 1'b1;
                        state_next  = ST_MOVE_RD;
                    end
                    else
                    begin
                        wr_data.size  = ev_rd.size - {8'd0, qty_reg};
                        wr_data.count = (ev_rd.count == '0) ? ev_rd.count
                                                            : ev_rd.count - 1'b1;
                    end
                end
                else if (is_add_reg && !(ev_used >= N_MAX && pos_reg >= N_MAX))
                begin
                    insert_next = 1'b1;
                    idx_next    = (ev_used >= N_MAX) ? N_MAX - 1'b1 : ev_used;
                    state_next  = ST_MOVE_RD;
                end
                rd_addr = idx_next[AW-1:0];
            end
            ST_MOVE_RD:
            begin
                // insert walks down from the tail, removal walks up from pos
                if (insert_reg)
                begin
                    if (idx_reg == pos_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = '{price: px_reg, size: {8'd0, qty_reg},
                                       count: CNT_W'(1)};
                        used_we    = 1'b1;
                        used_next  = (ev_used >= N_MAX) ? N_MAX : ev_used + 1'b1;
                        idx_next   = '0;
                        state_next = ST_DEP_RD;
                    end
                    else
                    begin
                        rd_addr    = AW'(idx_reg - 1'b1);
                        state_next = ST_MOVE_WR;
                    end
                end
                else if (idx_reg >= ev_used)
                begin
                    used_we    = 1'b1;
                    used_next  = ev_used - 1'b1;
                    idx_next   = '0;
                    state_next = ST_DEP_RD;
                end
                else
                    state_next = ST_MOVE_WR;
                if (state_next == ST_DEP_RD)
                    rd_addr = '0;
            end
            ST_MOVE_WR:
            begin
                wr_en = 1'b1;
                if (insert_reg)
                begin
                    wr_addr  = idx_reg[AW-1:0];
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    wr_addr  = AW'(idx_reg - 1'b1);
                    idx_next = idx_reg + 1'b1;
                end
                rd_addr    = idx_next[AW-1:0];
                state_next = ST_MOVE_RD;
            end
            ST_DEP_RD: state_next = ST_DEP;
            ST_DEP:
            begin
                if (at_end || !better || idx_reg >= NW'(DEPTH_CAP))
                    state_next = ST_OUT_RD;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    rd_addr    = idx_next[AW-1:0];
                    state_next = ST_DEP_RD;
                end
                if (state_next == ST_OUT_RD)
                    rd_addr = '0;
            end
            ST_OUT_RD:
            begin
                rd_addr    = AW'(k_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                rd_addr = AW'(k_reg);
                if (!out_valid_reg || !out_stall)
                begin
                    rd_addr = AW'(k_reg + 1'b1);
                    state_next = (k_reg == K_TOP - 1'b1) ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bid_used_reg  <= '0;
            ask_used_reg  <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pos_reg     <= pos_next;
            insert_reg  <= insert_next;
            if (used_we && is_bid_reg)
                bid_used_reg <= used_next;
            if (used_we && !is_bid_reg)
                ask_used_reg <= used_next;
            if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && !out_valid_reg)
                    begin
                        px_reg       <= price;
                        qty_reg      <= quantity;
                        is_bid_reg   <= (side == SIDE_BID);
                        is_add_reg   <= (command == CMD_ADD);
                        k_reg        <= '0;
                        trade_reg    <= (command == CMD_CANCEL) && (pend_reg == PEND_TRADE);
                        if (command == CMD_TRADE || command == CMD_FILL)
                        begin
                            if ((command == CMD_FILL || side == SIDE_BID ||
                                 side == SIDE_ASK) && pend_reg != PEND_MAX)
                                pend_reg <= pend_reg + 1'b1;
                        end
                        else if (command == CMD_CANCEL && pend_reg == PEND_TRADE)
                            pend_reg <= '0;
                    end
                end
                ST_DEP:
                begin
                    if (state_next == ST_OUT_RD)
                    begin
                        depth_reg <= (at_end || !better) ? IDX_W'(idx_reg)
                                                         : IDX_W'(DEPTH_CAP);
                        k_reg <= '0;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        oidx_reg  <= IDX_W'(k_reg);
                        obid_reg  <= bid_rd_reg;
                        oask_reg  <= ask_rd_reg;
                        obp_reg   <= NW'(k_reg) < bid_used_reg;
                        oap_reg   <= NW'(k_reg) < ask_used_reg;
                        olast_reg <= (k_reg == K_TOP - 1'b1);
                        k_reg     <= k_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign in_stall    = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid   = out_valid_reg;
    assign level_index = oidx_reg;
    assign bid_present = obp_reg;
    assign bid_price   = obp_reg ? obid_reg.price : '0;
    assign bid_total   = obp_reg ? obid_reg.size : '0;
    assign bid_orders  = obp_reg ? obid_reg.count : '0;
    assign ask_present = oap_reg;
    assign ask_price   = oap_reg ? oask_reg.price : '0;
    assign ask_total   = oap_reg ? oask_reg.size : '0;
    assign ask_orders  = oap_reg ? oask_reg.count : '0;
    assign event_depth = depth_reg;
    assign as_trade    = trade_reg;
    assign last        = olast_reg;

    a_used_bid: assert property (@(posedge clk) disable iff (!rst_n)
        bid_used_reg <= N_MAX) else $error("bid level count over capacity");
    a_used_ask: assert property (@(posedge clk) disable iff (!rst_n)
        ask_used_reg <= N_MAX) else $error("ask level count over capacity");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall) else $error("input open with transfer pending");
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |=> $stable(bid_used_reg) && $stable(ask_used_reg))
        else $error("level count changed on entry");
endmodule

// ----- tb/price_level_order_book_unit_test.sv -----
// testbench for the price level order book: directed table, random book events, self-checking
module price_level_order_book_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import plob_pkg::*;

    localparam int BOOK_DEPTH = 256;
    localparam int SNAP_LEVELS = 10;
    localparam logic [1:0] SIDE_NIL = 2'd2;
    localparam logic [1:0] SIDE_BAD = 2'd3;
    localparam logic [PRICE_W-1:0] PRICE_TOP = '1;
    localparam logic [QTY_W-1:0] QTY_TOP = '1;
    localparam logic [SIZE_W-1:0] SIZE_TOP = '1;
    localparam logic [CNT_W-1:0] CNT_TOP = '1;

    typedef struct packed {
        logic [IDX_W-1:0] level_index;
        logic [PRICE_W-1:0] bid_price;
        logic [SIZE_W-1:0] bid_total;
        logic [CNT_W-1:0] bid_orders;
        logic bid_present;
        logic [PRICE_W-1:0] ask_price;
        logic [SIZE_W-1:0] ask_total;
        logic [CNT_W-1:0] ask_orders;
        logic ask_present;
        logic [IDX_W-1:0] event_depth;
        logic as_trade;
        logic last;
    } snap_t;

    typedef struct {
        cmd_t cmd;
        logic [1:0] sd;
        logic [PRICE_W-1:0] px;
        logic [QTY_W-1:0] qty;
        bit typed;
        logic [SIZE_W-1:0] top_size;
        logic [CNT_W-1:0] top_count;
    } event_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] command = '0;
    logic [1:0] side = '0;
    logic [PRICE_W-1:0] price = '0;
    logic [QTY_W-1:0] quantity = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [IDX_W-1:0] level_index;
    logic [PRICE_W-1:0] bid_price, ask_price;
    logic [SIZE_W-1:0] bid_total, ask_total;
    logic [CNT_W-1:0] bid_orders, ask_orders;
    logic bid_present, ask_present, as_trade, last;
    logic [IDX_W-1:0] event_depth;

    price_level_order_book_unit uut (.*);

    always #1 clk = ~clk;

    // predicted book
    logic [PRICE_W-1:0] bid_px [BOOK_DEPTH], ask_px [BOOK_DEPTH];
    logic [SIZE_W-1:0] bid_sz [BOOK_DEPTH], ask_sz [BOOK_DEPTH];
    logic [CNT_W-1:0] bid_ct [BOOK_DEPTH], ask_ct [BOOK_DEPTH];
    int bid_used, ask_used;
    logic [1:0] fills_pending;

    snap_t expected_snaps [$];
    int fail_count = 0;
    int snaps_seen = 0;
    int events_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;

    function automatic bit px_better(bit is_bid, logic [PRICE_W-1:0] a,
                                     logic [PRICE_W-1:0] b);
        return is_bid ? (a > b) : (a < b);
    endfunction

    function automatic int level_slot(bit is_bid, logic [PRICE_W-1:0] p);
        int n;
        n = is_bid ? bid_used : ask_used;
        for (int i = 0; i < n; i++)
            if (!px_better(is_bid, is_bid ? bid_px[i] : ask_px[i], p)) return i;
        return n;
    endfunction

    task automatic book_add(bit is_bid, logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
        int pos, n;
        logic [SIZE_W:0] sum;
        pos = level_slot(is_bid, p);
        n = is_bid ? bid_used : ask_used;
        if (pos < n && (is_bid ? bid_px[pos] : ask_px[pos]) == p) begin
            if (is_bid) begin
                sum = bid_sz[pos] + q;
                bid_sz[pos] = sum[SIZE_W] ? SIZE_TOP : sum[SIZE_W-1:0];
                if (bid_ct[pos] != CNT_TOP) bid_ct[pos]++;
            end
            else begin
                sum = ask_sz[pos] + q;
                ask_sz[pos] = sum[SIZE_W] ? SIZE_TOP : sum[SIZE_W-1:0];
                if (ask_ct[pos] != CNT_TOP) ask_ct[pos]++;
            end
            return;
        end
        if (n >= BOOK_DEPTH) begin
            if (pos >= BOOK_DEPTH) return;
            n = BOOK_DEPTH - 1;
        end
        for (int i = n; i > pos; i--) begin
            if (is_bid) begin
                bid_px[i] = bid_px[i-1]; bid_sz[i] = bid_sz[i-1]; bid_ct[i] = bid_ct[i-1];
            end
            else begin
                ask_px[i] = ask_px[i-1]; ask_sz[i] = ask_sz[i-1]; ask_ct[i] = ask_ct[i-1];
            end
        end
        if (is_bid) begin
            bid_px[pos] = p; bid_sz[pos] = SIZE_W'(q); bid_ct[pos] = CNT_W'(1);
            bid_used = n + 1;
        end
        else begin
            ask_px[pos] = p; ask_sz[pos] = SIZE_W'(q); ask_ct[pos] = CNT_W'(1);
            ask_used = n + 1;
        end
    endtask

    task automatic book_cancel(bit is_bid, logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
        int pos, n;
        pos = level_slot(is_bid, p);
        n = is_bid ? bid_used : ask_used;
        if (!(pos < n && (is_bid ? bid_px[pos] : ask_px[pos]) == p)) return;
        if (q >= (is_bid ? bid_sz[pos] : ask_sz[pos])) begin
            for (int i = pos; i < n - 1; i++) begin
                if (is_bid) begin
                    bid_px[i] = bid_px[i+1]; bid_sz[i] = bid_sz[i+1]; bid_ct[i] = bid_ct[i+1];
                end
                else begin
                    ask_px[i] = ask_px[i+1]; ask_sz[i] = ask_sz[i+1]; ask_ct[i] = ask_ct[i+1];
                end
            end
            if (is_bid) bid_used = n - 1;
            else ask_used = n - 1;
        end
        else if (is_bid) begin
            bid_sz[pos] = bid_sz[pos] - SIZE_W'(q);
            if (bid_ct[pos] != 0) bid_ct[pos]--;
        end
        else begin
            ask_sz[pos] = ask_sz[pos] - SIZE_W'(q);
            if (ask_ct[pos] != 0) ask_ct[pos]--;
        end
    endtask

    task automatic apply_book_event(cmd_t c, logic [1:0] sd, logic [PRICE_W-1:0] p,
                                    logic [QTY_W-1:0] q);
        bit with_side, trade;
        int depth;
        snap_t s;
        with_side = (sd == SIDE_BID) || (sd == SIDE_ASK);
        trade = 1'b0;
        if (c == CMD_TRADE && !with_side) return;
        if (c == CMD_TRADE || c == CMD_FILL) begin
            if (fills_pending != PEND_MAX) fills_pending++;
            return;
        end
        if (c == CMD_CANCEL && fills_pending == PEND_TRADE) begin
            fills_pending = '0;
            trade = 1'b1;
        end
        if (with_side) begin
            if (c == CMD_ADD) book_add(sd == SIDE_BID, p, q);
            else book_cancel(sd == SIDE_BID, p, q);
        end
        depth = level_slot(sd == SIDE_BID, p);
        if (depth > DEPTH_CAP) depth = DEPTH_CAP;
        for (int k = 0; k < SNAP_LEVELS; k++) begin
            s = '0;
            s.level_index = IDX_W'(k);
            if (k < bid_used) begin
                s.bid_price = bid_px[k]; s.bid_total = bid_sz[k];
                s.bid_orders = bid_ct[k]; s.bid_present = 1'b1;
            end
            if (k < ask_used) begin
                s.ask_price = ask_px[k]; s.ask_total = ask_sz[k];
                s.ask_orders = ask_ct[k]; s.ask_present = 1'b1;
            end
            s.event_depth = IDX_W'(depth);
            s.as_trade = trade;
            s.last = (k == SNAP_LEVELS - 1);
            expected_snaps = {expected_snaps, s};
        end
    endtask

    task automatic send_event(cmd_t c, logic [1:0] sd, logic [PRICE_W-1:0] p,
                              logic [QTY_W-1:0] q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        side <= sd;
        price <= p;
        quantity <= q;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        apply_book_event(c, sd, p, q);
        events_sent++;
    endtask

    task automatic drain_snaps();
        in_valid <= 1'b0;
        while (expected_snaps.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // book prices near a mid point keep levels colliding
    function automatic logic [PRICE_W-1:0] pick_price(logic [1:0] sd);
        case ($urandom_range(9))
            0: return PRICE_W'({$urandom, $urandom} & PRICE_TOP);
            1: return $urandom_range(1) ? PRICE_TOP : '0;
            default: return (sd == SIDE_BID) ? 36'd1000 - $urandom_range(24)
                                             : 36'd1001 + $urandom_range(24);
        endcase
    endfunction

    function automatic logic [QTY_W-1:0] pick_qty();
        case ($urandom_range(7))
            0: return QTY_TOP;
            1: return '0;
            2: return QTY_W'($urandom);
            default: return QTY_W'($urandom_range(500, 1));
        endcase
    endfunction

    task automatic random_events(int n);
        cmd_t c;
        logic [1:0] sd;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0, 1: c = CMD_TRADE;
                2, 3: c = CMD_FILL;
                4, 5, 6, 7, 8, 9: c = CMD_CANCEL;
                default: c = CMD_ADD;
            endcase
            sd = ($urandom_range(15) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
            send_event(c, sd, pick_price(sd), pick_qty());
        end
    endtask

    // receiver
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            snap_t got, want;
            got = {level_index, bid_price, bid_total, bid_orders, bid_present,
                   ask_price, ask_total, ask_orders, ask_present, event_depth,
                   as_trade, last};
            snaps_seen++;
            if (expected_snaps.size() == 0) begin
                $error("unexpected transfer level_index=%0d", level_index);
                fail_count++;
            end
            else begin
                want = expected_snaps.pop_front();
                if (got != want) begin
                    fail_count++;
                    if (got.level_index != want.level_index)
                        $error("level_index exp %0d got %0d", want.level_index, got.level_index);
                    if (got.bid_price != want.bid_price)
                        $error("bid_price exp %0d got %0d", want.bid_price, got.bid_price);
                    if (got.bid_total != want.bid_total)
                        $error("bid_total exp %0d got %0d", want.bid_total, got.bid_total);
                    if (got.bid_orders != want.bid_orders)
                        $error("bid_orders exp %0d got %0d", want.bid_orders, got.bid_orders);
                    if (got.bid_present != want.bid_present)
                        $error("bid_present exp %0d got %0d", want.bid_present, got.bid_present);
                    if (got.ask_price != want.ask_price)
                        $error("ask_price exp %0d got %0d", want.ask_price, got.ask_price);
                    if (got.ask_total != want.ask_total)
                        $error("ask_total exp %0d got %0d", want.ask_total, got.ask_total);
                    if (got.ask_orders != want.ask_orders)
                        $error("ask_orders exp %0d got %0d", want.ask_orders, got.ask_orders);
                    if (got.ask_present != want.ask_present)
                        $error("ask_present exp %0d got %0d", want.ask_present, got.ask_present);
                    if (got.event_depth != want.event_depth)
                        $error("event_depth exp %0d got %0d", want.event_depth, got.event_depth);
                    if (got.as_trade != want.as_trade)
                        $error("as_trade exp %0d got %0d", want.as_trade, got.as_trade);
                    if (got.last != want.last)
                        $error("last exp %0d got %0d", want.last, got.last);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // long receiver hold-off while events keep arriving
    initial begin
        wait (events_sent >= 60);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        event_row_t rows [$];
        event_row_t r;
        int idle_sets [4][2];
        bid_used = 0;
        ask_used = 0;
        fills_pending = '0;
        idle_sets = '{'{0, 0}, '{69, 0}, '{0, 69}, '{37, 37}};
        // directed: extremes, saturation, side none, absent cancel, trade sequence
        rows = '{
            '{CMD_ADD, SIDE_BID, PRICE_TOP, QTY_TOP, 1, 32'(QTY_TOP), 16'd1},
            '{CMD_ADD, SIDE_ASK, '0, '0, 0, '0, '0},
            '{CMD_ADD, SIDE_BID, '0, 24'd5, 0, '0, '0},
            '{CMD_ADD, SIDE_ASK, PRICE_TOP, 24'd7, 0, '0, '0},
            '{CMD_ADD, SIDE_NIL, 36'd50, 24'd1, 0, '0, '0},
            '{CMD_CANCEL, SIDE_BAD, 36'd50, 24'd1, 0, '0, '0},
            '{CMD_CANCEL, SIDE_BID, 36'd77, 24'd1, 0, '0, '0},
            '{CMD_CANCEL, SIDE_BID, PRICE_TOP, 24'd1, 1, 32'(QTY_TOP) - 1, 16'd0},
            '{CMD_CANCEL, SIDE_BID, PRICE_TOP, 24'd2, 0, '0, '0},
            '{CMD_TRADE, SIDE_NIL, 36'd1, 24'd1, 0, '0, '0},
            '{CMD_TRADE, SIDE_BID, 36'd1, 24'd1, 0, '0, '0},
            '{CMD_FILL, SIDE_NIL, 36'd1, 24'd1, 0, '0, '0},
            '{CMD_CANCEL, SIDE_ASK, PRICE_TOP, 24'd7, 0, '0, '0},
            '{CMD_FILL, SIDE_ASK, 36'd1, 24'd1, 0, '0, '0},
            '{CMD_FILL, SIDE_BID, 36'd1, 24'd1, 0, '0, '0},
            '{CMD_FILL, SIDE_BAD, 36'd1, 24'd1, 0, '0, '0},
            '{CMD_CANCEL, SIDE_ASK, '0, QTY_TOP, 0, '0, '0}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i]) begin
            r = rows[i];
            send_event(r.cmd, r.sd, r.px, r.qty);
            if (r.typed) begin
                if (bid_sz[0] != r.top_size || bid_ct[0] != r.top_count) begin
                    $error("bid level 0 exp %0d/%0d", r.top_size, r.top_count);
                    fail_count++;
                end
            end
        end
        drain_snaps();
        // full table: more distinct bid levels than the book holds
        for (int i = 0; i < BOOK_DEPTH + 4; i++)
            send_event(CMD_ADD, SIDE_BID, 36'd2000 + i, 24'd1);
        send_event(CMD_ADD, SIDE_BID, 36'd3, 24'd1);
        drain_snaps();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_sets[ph][0];
            recv_stall_pct = idle_sets[ph][1];
            random_events(21);
            drain_snaps();
        end
        repeat (40) @(posedge clk);
        $display("ran %0d book events, %0d snapshot transfers checked", events_sent,
                 snaps_seen);
        $display("covered extremes, saturation, full table, trade closes and idle mixes");
        if (fail_count == 0 && expected_snaps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
sv/plob_pkg.sv
sv/price_level_order_book_unit.sv
tb/price_level_order_book_unit_test.sv
